// ===== design/epm_pkg.sv =====
`timescale 1ns / 1ps

package epm_pkg;

  localparam int COUNT_WIDTH = 24;

  localparam int CMD_W      = 2;
  localparam int TGT_W      = 24;
  localparam int POS_W      = 24;
  localparam int DRV_W      = 9;
  localparam int PWM_W      = 8;
  localparam int GAIN_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int GAIN_SHIFT = 8;
  localparam int KP_PROD_W  = COUNT_WIDTH + GAIN_W + 1;
  localparam int KD_PROD_W  = COUNT_WIDTH + GAIN_W + 2;
  localparam int SUM_W      = COUNT_WIDTH + GAIN_W + 3;
  localparam int QUO_W      = SUM_W - GAIN_SHIFT;
  localparam int CLAMP_W    = 10;
  localparam int ROUND_ADD  = (1 << GAIN_SHIFT) - 1;

  localparam int SPEED_LIMIT = 200;
  localparam int DRIVE_LOW   = -200;
  localparam int DRIVE_HIGH  = 170;

  localparam logic [GAIN_W-1:0] KP_RESET          = GAIN_W'(77);
  localparam logic [GAIN_W-1:0] KD_RESET          = GAIN_W'(256);
  localparam logic [BYTE_W-1:0] FLOOR_SPEED_RESET = BYTE_W'(50);
  localparam logic [BYTE_W-1:0] STOP_BAND_RESET   = BYTE_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP          = 2'd0,
    CFG_KD          = 2'd1,
    CFG_FLOOR_SPEED = 2'd2,
    CFG_STOP_BAND   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_ZERO    = 2'd1,
    OP_COMPUTE = 2'd2
  } drive_op_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
    logic [BYTE_W-1:0] floor_speed;
    logic [BYTE_W-1:0] stop_band;
  } cfg_t;

  typedef struct packed {
    drive_op_e                      op;
    logic signed [COUNT_WIDTH-1:0]  err;
    logic signed [COUNT_WIDTH:0]    derr;
    logic signed [POS_W-1:0]        position;
    logic                           done;
  } track_t;

  typedef struct packed {
    drive_op_e                    op;
    logic signed [KP_PROD_W-1:0]  kp_prod;
    logic signed [KD_PROD_W-1:0]  kd_prod;
    logic signed [POS_W-1:0]      position;
    logic                         done;
  } prod_t;

endpackage

// ===== design/epm_ifs.sv =====
`timescale 1ns / 1ps

interface epm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [epm_pkg::CMD_W-1:0]            cmd;
  logic                                 enc_a;
  logic                                 enc_b;
  logic signed [epm_pkg::TGT_W-1:0]     target_counts;

  modport source (output valid, cmd, enc_a, enc_b, target_counts, input ready);
  modport sink (input valid, cmd, enc_a, enc_b, target_counts, output ready);
endinterface

interface epm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [epm_pkg::DRV_W-1:0]     drive;
  logic [epm_pkg::PWM_W-1:0]            pwm_duty;
  logic                                 dir_fwd;
  logic                                 dir_rev;
  logic                                 done_res;
  logic signed [epm_pkg::POS_W-1:0]     position;

  modport source (output valid, drive, pwm_duty, dir_fwd, dir_rev, done_res, position,
                  input ready);
  modport sink (input valid, drive, pwm_duty, dir_fwd, dir_rev, done_res, position,
                output ready);
endinterface

// ===== design/epm_track.sv =====
`timescale 1ns / 1ps

module epm_track (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                load_i,
  input  logic [epm_pkg::BYTE_W-1:0]          stop_band_i,
  input  logic [epm_pkg::CMD_W-1:0]           cmd_i,
  input  logic                                enc_a_i,
  input  logic                                enc_b_i,
  input  logic signed [epm_pkg::TGT_W-1:0]    target_counts_i,
  output logic                                valid_o,
  output epm_pkg::track_t                     track_o
);
  import epm_pkg::*;

  localparam logic signed [COUNT_WIDTH-1:0] ERR_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] ERR_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  logic signed [COUNT_WIDTH-1:0] count_q, count_d;
  logic signed [COUNT_WIDTH-1:0] target_q, target_d;
  logic signed [COUNT_WIDTH-1:0] last_q, last_d;
  logic                          active_q, active_d;
  logic                          done_q, done_d;
  logic                          valid_q;
  track_t                        track_q, track_d;

  logic signed [COUNT_WIDTH:0]   diff;
  logic signed [COUNT_WIDTH-1:0] err;
  logic [COUNT_WIDTH-1:0]        err_mag;
  logic                          in_band;

  always_comb begin
    diff = {target_q[COUNT_WIDTH-1], target_q} - {count_q[COUNT_WIDTH-1], count_q};
    if (diff[COUNT_WIDTH] != diff[COUNT_WIDTH-1]) begin
      err = diff[COUNT_WIDTH] ? ERR_MIN : ERR_MAX;
    end else begin
      err = diff[COUNT_WIDTH-1:0];
    end
    err_mag = err[COUNT_WIDTH-1] ? (~err + COUNT_WIDTH'(1)) : err;
    in_band = err_mag < COUNT_WIDTH'(stop_band_i);
  end

  always_comb begin
    count_d  = count_q;
    target_d = target_q;
    last_d   = last_q;
    active_d = active_q;
    done_d   = done_q;
    track_d.op   = OP_HOLD;
    track_d.err  = err;
    track_d.derr = {err[COUNT_WIDTH-1], err} - {last_q[COUNT_WIDTH-1], last_q};
    unique case (cmd_e'(cmd_i))
      CMD_EDGE: begin
        if (enc_a_i == enc_b_i) begin
          count_d = count_q + COUNT_WIDTH'(1);
        end else begin
          count_d = count_q - COUNT_WIDTH'(1);
        end
      end
      CMD_TICK: begin
        if (active_q) begin
          last_d = err;
          if (in_band) begin
            done_d     = 1'b1;
            active_d   = 1'b0;
            track_d.op = OP_ZERO;
          end else begin
            track_d.op = OP_COMPUTE;
          end
        end
      end
      CMD_START: begin
        target_d   = COUNT_WIDTH'(target_counts_i);
        count_d    = '0;
        last_d     = '0;
        done_d     = 1'b0;
        active_d   = 1'b1;
        track_d.op = OP_ZERO;
      end
      default: begin
      end
    endcase
    track_d.position = POS_W'(count_d);
    track_d.done     = done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      target_q <= '0;
      last_q   <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (accept_i) begin
        count_q  <= count_d;
        target_q <= target_d;
        last_q   <= last_d;
        active_q <= active_d;
        done_q   <= done_d;
      end
      if (load_i) begin
        valid_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      track_q <= track_d;
    end
  end

  assign valid_o = valid_q;
  assign track_o = track_q;

endmodule

// ===== design/epm_mult.sv =====
`timescale 1ns / 1ps

module epm_mult (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  epm_pkg::cfg_t    cfg_i,
  input  logic             valid_i,
  input  epm_pkg::track_t  track_i,
  output logic             valid_o,
  output epm_pkg::prod_t   prod_o
);
  import epm_pkg::*;

  logic  valid_q;
  prod_t prod_q, prod_d;

  always_comb begin
    prod_d.op       = track_i.op;
    prod_d.kp_prod  = $signed({1'b0, cfg_i.kp}) * track_i.err;
    prod_d.kd_prod  = $signed({1'b0, cfg_i.kd}) * track_i.derr;
    prod_d.position = track_i.position;
    prod_d.done     = track_i.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ===== design/epm_shape.sv =====
`timescale 1ns / 1ps

module epm_shape (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [epm_pkg::BYTE_W-1:0]        floor_speed_i,
  input  logic                              valid_i,
  input  epm_pkg::prod_t                    prod_i,
  output logic                              valid_o,
  output logic signed [epm_pkg::DRV_W-1:0]  drive_o,
  output logic [epm_pkg::PWM_W-1:0]         pwm_duty_o,
  output logic                              dir_fwd_o,
  output logic                              dir_rev_o,
  output logic                              done_res_o,
  output logic signed [epm_pkg::POS_W-1:0]  position_o
);
  import epm_pkg::*;

  logic                      valid_q;
  logic signed [DRV_W-1:0]   drive_q, drive_d;
  logic [PWM_W-1:0]          pwm_q, pwm_d;
  logic                      fwd_q, rev_q;
  logic                      done_q;
  logic signed [POS_W-1:0]   pos_q;

  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   rnd;
  logic signed [QUO_W-1:0]   quo;
  logic signed [CLAMP_W-1:0] spd;
  logic signed [CLAMP_W-1:0] ms;

  always_comb begin
    sum = SUM_W'(prod_i.kp_prod) + SUM_W'(prod_i.kd_prod);
    rnd = sum + (sum[SUM_W-1] ? SUM_W'(ROUND_ADD) : SUM_W'(0));
    quo = rnd[SUM_W-1:GAIN_SHIFT];
    ms  = {2'b00, floor_speed_i};

    if (quo > SPEED_LIMIT) begin
      spd = CLAMP_W'(SPEED_LIMIT);
    end else if (quo < -SPEED_LIMIT) begin
      spd = CLAMP_W'(-SPEED_LIMIT);
    end else begin
      spd = quo[CLAMP_W-1:0];
    end

    if (spd > 0 && spd < ms) begin
      spd = ms;
    end else if (spd < 0 && spd > -ms) begin
      spd = -ms;
    end

    if (spd > DRIVE_HIGH) begin
      spd = CLAMP_W'(DRIVE_HIGH);
    end else if (spd < DRIVE_LOW) begin
      spd = CLAMP_W'(DRIVE_LOW);
    end

    unique case (prod_i.op)
      OP_ZERO:    drive_d = '0;
      OP_COMPUTE: drive_d = spd[DRV_W-1:0];
      default:    drive_d = drive_q;
    endcase
    pwm_d = drive_d[DRV_W-1] ? PWM_W'(-drive_d) : PWM_W'(drive_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      drive_q <= '0;
    end else if (load_i) begin
      valid_q <= valid_i;
      if (valid_i) begin
        drive_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && valid_i) begin
      pwm_q  <= pwm_d;
      fwd_q  <= !drive_d[DRV_W-1] && (drive_d != '0);
      rev_q  <= drive_d[DRV_W-1];
      done_q <= prod_i.done;
      pos_q  <= prod_i.position;
    end
  end

  assign valid_o    = valid_q;
  assign drive_o    = drive_q;
  assign pwm_duty_o = pwm_q;
  assign dir_fwd_o  = fwd_q;
  assign dir_rev_o  = rev_q;
  assign done_res_o = done_q;
  assign position_o = pos_q;

endmodule

// ===== design/encoder_pd_position_move_core.sv =====
`timescale 1ns / 1ps

// PD position controller with a quadrature position count.
// Items arrive on in_ch: an encoder edge steps the count up or down, a control
// tick runs one PD step towards the target, and a start loads a new target and
// clears the count, the previous error and the done flag.
// Every item produces exactly one result item on out_ch, carrying the held
// motor drive, its PWM duty and direction pins, the done flag and the count.
// The block takes one item per clock while out_ch takes its results; the count
// and error update in the first stage, the two gain multiplications sit in the
// second, and the drive shaping feeds the output register in the third.
// When out_ch stalls, the pipeline fills its empty stages and then drops
// in_ch.ready until the waiting result is taken; no item is lost.
// Gains, minimum speed and stop band are written through the cfg port while
// the block is idle. Reset restores the default configuration and clears the
// count, target, drive and internal flags; the block is ready straight after.

module encoder_pd_position_move_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  epm_in_if.sink                             in_ch,
  epm_out_if.source                          out_ch,
  input  logic                               cfg_we_i,
  input  logic [epm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [epm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import epm_pkg::*;

  cfg_t   cfg_q;
  logic   v1, v2;
  track_t track;
  prod_t  prod;
  logic   out_free, s2_free, s1_free, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp          <= KP_RESET;
      cfg_q.kd          <= KD_RESET;
      cfg_q.floor_speed <= FLOOR_SPEED_RESET;
      cfg_q.stop_band   <= STOP_BAND_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KP:          cfg_q.kp          <= cfg_data_i[GAIN_W-1:0];
        CFG_KD:          cfg_q.kd          <= cfg_data_i[GAIN_W-1:0];
        CFG_FLOOR_SPEED: cfg_q.floor_speed <= cfg_data_i[BYTE_W-1:0];
        CFG_STOP_BAND:   cfg_q.stop_band   <= cfg_data_i[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_free    = !out_ch.valid || out_ch.ready;
  assign s2_free     = !v2 || out_free;
  assign s1_free     = !v1 || s2_free;
  assign in_ch.ready = s1_free;
  assign accept      = in_ch.valid && s1_free;

  epm_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .load_i          (s1_free),
    .stop_band_i     (cfg_q.stop_band),
    .cmd_i           (in_ch.cmd),
    .enc_a_i         (in_ch.enc_a),
    .enc_b_i         (in_ch.enc_b),
    .target_counts_i (in_ch.target_counts),
    .valid_o         (v1),
    .track_o         (track)
  );

  epm_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s2_free),
    .cfg_i   (cfg_q),
    .valid_i (v1),
    .track_i (track),
    .valid_o (v2),
    .prod_o  (prod)
  );

  epm_shape u_shape (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_free),
    .floor_speed_i (cfg_q.floor_speed),
    .valid_i       (v2),
    .prod_i        (prod),
    .valid_o       (out_ch.valid),
    .drive_o       (out_ch.drive),
    .pwm_duty_o    (out_ch.pwm_duty),
    .dir_fwd_o     (out_ch.dir_fwd),
    .dir_rev_o     (out_ch.dir_rev),
    .done_res_o    (out_ch.done_res),
    .position_o    (out_ch.position)
  );

  a_free_out_frees_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_free |-> in_ch.ready)
    else $error("input stalled while the output side is free");

  a_drive_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.drive >= DRIVE_LOW) && (out_ch.drive <= DRIVE_HIGH))
    else $error("drive outside its permitted range");

  a_dir_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !(out_ch.dir_fwd && out_ch.dir_rev))
    else $error("both direction pins raised");

  a_idle_duty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.dir_fwd && !out_ch.dir_rev) |-> (out_ch.pwm_duty == '0))
    else $error("nonzero duty with no direction");

endmodule
